@@ src/tpad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point angle package
// Shared widths, constants and the elaboration-time arctangent table
// generator for the three-point angle unit.
// ----------------------------------------------------------------------------
package tpad_pkg;

    // Default parameter values.
    localparam int COORD_BITS_DEF      = 32;
    localparam int CORDIC_STAGES_DEF   = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Magnitudes are brought below 2^FIT_BITS before each multiply.
    localparam int FIT_BITS = 30;
    localparam int FIT_W    = FIT_BITS + 1;
    // Width of one product of two fitted values.
    localparam int PROD_W   = 2 * FIT_W;
    // Width of the cross and dot product terms and of the root remainder.
    localparam int WIDE_W   = 64;
    // Shift amount width for fitting a wide term.
    localparam int VSH_W    = 6;
    // CORDIC vector width and angle accumulator width (radians Q60).
    localparam int CX_W     = 35;
    localparam int Z_W      = 64;
    // Rounded radians Q30 width.
    localparam int Z30_W    = 32;
    // Output angle width.
    localparam int ANGLE_W  = 24;

    // 180/pi in Q26.
    localparam logic [31:0] DEG_PER_RAD_Q26 = 32'd3845054675;

    // Unsigned restoring division, used only while elaborating constants.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[63:0], num[j]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in radians Q60 from truncated Taylor series terms.
    function automatic logic signed [63:0] atan_inv(input logic [63:0] n);
        logic [63:0]        p;
        logic [63:0]        term;
        logic signed [63:0] sum;
        p   = udiv64(64'd1 << 60, n);
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                term = udiv64(p, 64'(2 * k + 1));
                if (k % 2 == 0) begin
                    sum = sum + $signed(term);
                end else begin
                    sum = sum - $signed(term);
                end
                p = udiv64(udiv64(p, n), n);
            end
        end
        return sum;
    endfunction

    // Rotation angle of one CORDIC step; step zero is pi/4 by Machin's formula.
    function automatic logic signed [63:0] atan_stage(input int i);
        logic signed [63:0] a;
        if (i == 0) begin
            a = 4 * atan_inv(64'd5) - atan_inv(64'd239);
        end else begin
            a = atan_inv(64'd1 << i);
        end
        return a;
    endfunction

    localparam logic signed [Z_W-1:0] HALF_PI_Q60 = 2 * atan_stage(0);

endpackage

@@ src/tpad_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point angle input channel
// Valid/ready channel that carries one origin point and two end points.
// ----------------------------------------------------------------------------
interface tpad_in_if
    import tpad_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
               second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
               second_x, second_y, second_z,
        output ready
    );
endinterface

@@ src/tpad_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point angle output channel
// Valid/ready channel that carries one angle result.
// ----------------------------------------------------------------------------
interface tpad_out_if
    import tpad_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_degrees;
    logic               degenerate;

    modport source (output valid, angle_degrees, degenerate, input ready);
    modport sink (input valid, angle_degrees, degenerate, output ready);
endinterface

@@ src/three_point_angle_degrees_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point angle unit
// Angle at a vertex between two 3D points, in degrees, computed as
// atan2(|a x b|, a.b) with a pipelined square root and vectoring CORDIC.
// ----------------------------------------------------------------------------
// The unit accepts one point triple per cycle while no finished result is
// stalled at the output, and returns one angle per beat in the same order,
// 0 to 180 degrees in unsigned Q8.ANGLE_FRAC_BITS. The pipeline forms, scales
// and multiplies the difference vectors, produces one square root bit per
// stage, pre-rotates, takes one CORDIC step per stage and converts to
// degrees. The whole pipeline holds while a finished result waits at the
// output, so no beat is lost. A zero-length difference vector gives a zero
// angle with the degenerate flag set.
// ----------------------------------------------------------------------------
module three_point_angle_degrees_unit
    import tpad_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpad_in_if.sink   i_in,
    tpad_out_if.source o_out
);

    localparam int DW   = COORD_BITS + 1;
    localparam int EW   = (DW > FIT_W) ? DW : FIT_W;
    localparam int SHW  = $clog2(EW);
    localparam int RW   = FIT_W;
    localparam int NST  = 13 + RW + CORDIC_STAGES;
    localparam int RSH  = 56 - ANGLE_FRAC_BITS;
    localparam int XT   = EW - COORD_BITS;

    logic adv;

    // Valid and degenerate flags travel together down the pipeline.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_dg;
    logic           n_dg;

    assign adv        = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready = adv;

    assign n_dg = (i_in.first_x == i_in.origin_x && i_in.first_y == i_in.origin_y &&
                   i_in.first_z == i_in.origin_z) ||
                  (i_in.second_x == i_in.origin_x && i_in.second_y == i_in.origin_y &&
                   i_in.second_z == i_in.origin_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dg <= {r_dg[NST-2:0], n_dg};
        end
    end

    // Stage 1: difference vectors, exact.
    logic signed [EW-1:0] r_a1 [3];
    logic signed [EW-1:0] r_b1 [3];
    logic signed [EW-1:0] n_o  [3];
    logic signed [EW-1:0] n_f  [3];
    logic signed [EW-1:0] n_s  [3];

    always_comb begin
        n_o[0] = {{XT{i_in.origin_x[COORD_BITS-1]}}, i_in.origin_x};
        n_o[1] = {{XT{i_in.origin_y[COORD_BITS-1]}}, i_in.origin_y};
        n_o[2] = {{XT{i_in.origin_z[COORD_BITS-1]}}, i_in.origin_z};
        n_f[0] = {{XT{i_in.first_x[COORD_BITS-1]}}, i_in.first_x};
        n_f[1] = {{XT{i_in.first_y[COORD_BITS-1]}}, i_in.first_y};
        n_f[2] = {{XT{i_in.first_z[COORD_BITS-1]}}, i_in.first_z};
        n_s[0] = {{XT{i_in.second_x[COORD_BITS-1]}}, i_in.second_x};
        n_s[1] = {{XT{i_in.second_y[COORD_BITS-1]}}, i_in.second_y};
        n_s[2] = {{XT{i_in.second_z[COORD_BITS-1]}}, i_in.second_z};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= n_f[k] - n_o[k];
                r_b1[k] <= n_s[k] - n_o[k];
            end
        end
    end

    // Stage 2: scale shift per vector from the highest magnitude bit.
    logic signed [EW-1:0] r_a2 [3];
    logic signed [EW-1:0] r_b2 [3];
    logic [SHW-1:0]       r_sa2;
    logic [SHW-1:0]       r_sb2;
    logic [EW-1:0]        n_ma;
    logic [EW-1:0]        n_mb;
    logic [SHW-1:0]       n_sa;
    logic [SHW-1:0]       n_sb;

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        for (int k = 0; k < 3; k++) begin
            n_ma = n_ma | (r_a1[k][EW-1] ? $unsigned(-r_a1[k]) : $unsigned(r_a1[k]));
            n_mb = n_mb | (r_b1[k][EW-1] ? $unsigned(-r_b1[k]) : $unsigned(r_b1[k]));
        end
        n_sa = '0;
        n_sb = '0;
        for (int b = FIT_BITS; b < EW; b++) begin
            if (n_ma[b]) begin
                n_sa = SHW'(b - FIT_BITS + 1);
            end
            if (n_mb[b]) begin
                n_sb = SHW'(b - FIT_BITS + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_sa2 <= n_sa;
            r_sb2 <= n_sb;
        end
    end

    // Stage 3: apply the floor shifts.
    logic signed [FIT_W-1:0] r_a3 [3];
    logic signed [FIT_W-1:0] r_b3 [3];
    logic signed [EW-1:0]    n_as [3];
    logic signed [EW-1:0]    n_bs [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_as[k] = r_a2[k] >>> r_sa2;
            n_bs[k] = r_b2[k] >>> r_sb2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_a3[k] <= n_as[k][FIT_W-1:0];
                r_b3[k] <= n_bs[k][FIT_W-1:0];
            end
        end
    end

    // Stage 4: the nine partial products of the cross and dot products.
    logic signed [PROD_W-1:0] r_p [9];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0] <= r_a3[1] * r_b3[2];
            r_p[1] <= r_a3[2] * r_b3[1];
            r_p[2] <= r_a3[2] * r_b3[0];
            r_p[3] <= r_a3[0] * r_b3[2];
            r_p[4] <= r_a3[0] * r_b3[1];
            r_p[5] <= r_a3[1] * r_b3[0];
            r_p[6] <= r_a3[0] * r_b3[0];
            r_p[7] <= r_a3[1] * r_b3[1];
            r_p[8] <= r_a3[2] * r_b3[2];
        end
    end

    // Stage 5: cross product components and dot product.
    logic signed [WIDE_W-1:0] r_v5 [4];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_v5[0] <= WIDE_W'(r_p[0]) - WIDE_W'(r_p[1]);
            r_v5[1] <= WIDE_W'(r_p[2]) - WIDE_W'(r_p[3]);
            r_v5[2] <= WIDE_W'(r_p[4]) - WIDE_W'(r_p[5]);
            r_v5[3] <= WIDE_W'(r_p[6]) + WIDE_W'(r_p[7]) + WIDE_W'(r_p[8]);
        end
    end

    // Stage 6: common scale shift for the four terms.
    logic signed [WIDE_W-1:0] r_v6 [4];
    logic [VSH_W-1:0]         r_sv6;
    logic [WIDE_W-1:0]        n_mv;
    logic [VSH_W-1:0]         n_sv;

    always_comb begin
        n_mv = '0;
        for (int k = 0; k < 4; k++) begin
            n_mv = n_mv | (r_v5[k][WIDE_W-1] ? $unsigned(-r_v5[k]) : $unsigned(r_v5[k]));
        end
        n_sv = '0;
        for (int b = FIT_BITS; b < WIDE_W; b++) begin
            if (n_mv[b]) begin
                n_sv = VSH_W'(b - FIT_BITS + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_v6  <= r_v5;
            r_sv6 <= n_sv;
        end
    end

    // Stage 7: apply the common shift.
    logic signed [FIT_W-1:0]  r_v7 [4];
    logic signed [WIDE_W-1:0] n_vs [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_vs[k] = r_v6[k] >>> r_sv6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_v7[k] <= n_vs[k][FIT_W-1:0];
            end
        end
    end

    // Stage 8: squares of the cross product components.
    logic signed [PROD_W-1:0] r_q8 [3];
    logic signed [FIT_W-1:0]  r_d8;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_q8[k] <= r_v7[k] * r_v7[k];
            end
            r_d8 <= r_v7[3];
        end
    end

    // Stage 9 seeds the root pipeline; each later stage settles one root bit.
    logic [WIDE_W-1:0]       r_rem  [RW+1];
    logic [RW-1:0]           r_root [RW+1];
    logic signed [FIT_W-1:0] r_sd   [RW+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0]  <= WIDE_W'($unsigned(r_q8[0])) + WIDE_W'($unsigned(r_q8[1])) +
                         WIDE_W'($unsigned(r_q8[2]));
            r_root[0] <= '0;
            r_sd[0]   <= r_d8;
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int K = RW - 1 - j;
        logic [WIDE_W-1:0] n_t;

        // Trial subtrahend (root + 2^K)^2 - root^2.
        assign n_t = (WIDE_W'(r_root[j]) << (K + 1)) + (WIDE_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_rem[j] >= n_t) begin
                    r_rem[j+1]  <= r_rem[j] - n_t;
                    r_root[j+1] <= r_root[j] | (RW'(1) << K);
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
                r_sd[j+1] <= r_sd[j];
            end
        end
    end

    // Pre-rotation into the right half plane for a negative dot product.
    logic signed [CX_W-1:0] r_cx [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] r_cy [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  r_cz [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_sd[RW][FIT_W-1]) begin
                r_cx[0] <= CX_W'(r_root[RW]);
                r_cy[0] <= -CX_W'(r_sd[RW]);
                r_cz[0] <= HALF_PI_Q60;
            end else begin
                r_cx[0] <= CX_W'(r_sd[RW]);
                r_cy[0] <= CX_W'(r_root[RW]);
                r_cz[0] <= '0;
            end
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage.
    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
        localparam logic signed [Z_W-1:0] ATAN = atan_stage(j);
        logic signed [CX_W-1:0] n_xs;
        logic signed [CX_W-1:0] n_ys;

        assign n_xs = r_cx[j] >>> j;
        assign n_ys = r_cy[j] >>> j;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_cy[j][CX_W-1]) begin
                    r_cx[j+1] <= r_cx[j] + n_ys;
                    r_cy[j+1] <= r_cy[j] - n_xs;
                    r_cz[j+1] <= r_cz[j] + ATAN;
                end else begin
                    r_cx[j+1] <= r_cx[j] - n_ys;
                    r_cy[j+1] <= r_cy[j] + n_xs;
                    r_cz[j+1] <= r_cz[j] - ATAN;
                end
            end
        end
    end

    // Clamp and round to radians Q30.
    logic [Z30_W-1:0] r_z30;
    logic [Z_W-1:0]   n_zr;

    always_comb begin
        if (r_cz[CORDIC_STAGES][Z_W-1]) begin
            n_zr = '0;
        end else begin
            n_zr = $unsigned(r_cz[CORDIC_STAGES]) + (Z_W'(1) << 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z30 <= n_zr[Z30_W+29:30];
        end
    end

    // Convert to degrees Q56.
    logic [WIDE_W-1:0] r_deg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_deg <= WIDE_W'(r_z30) * WIDE_W'(DEG_PER_RAD_Q26);
        end
    end

    // Round to the output fraction, saturate at 180 degrees.
    logic [ANGLE_W-1:0] r_ang;
    logic [WIDE_W:0]    n_rnd;
    logic [WIDE_W:0]    n_ang;
    logic [WIDE_W:0]    n_lim;

    always_comb begin
        n_rnd = {1'b0, r_deg} + ((WIDE_W + 1)'(1) << (RSH - 1));
        n_ang = n_rnd >> RSH;
        n_lim = (WIDE_W + 1)'(180) << ANGLE_FRAC_BITS;
        if (n_ang > n_lim) begin
            n_ang = n_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang <= r_dg[NST-2] ? '0 : n_ang[ANGLE_W-1:0];
        end
    end

    assign o_out.valid         = r_vld[NST-1];
    assign o_out.angle_degrees = r_ang;
    assign o_out.degenerate    = r_dg[NST-1];

endmodule

@@ test/three_point_angle_degrees_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point angle unit testbench
// Sends point triples through the input channel under random idle and stall
// bursts, and predicts each angle with an independent integer model of the
// fitted cross and dot products, the root and the vectoring CORDIC. Every
// result beat is checked in order against the predicted angle and flag.
// ----------------------------------------------------------------------------
module three_point_angle_degrees_unit_tb
    import tpad_pkg::*;
;

    localparam int NUM_RANDOM  = 2000;
    localparam int QUIET_TAIL  = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int STAGES      = CORDIC_STAGES_DEF;
    localparam int FRAC        = ANGLE_FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] pt[9];
    } t_triple;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic               degen;
    } t_angle;

    logic i_clk;
    logic i_rst_n;

    tpad_in_if #(.COORD_BITS(32)) in_ch();
    tpad_out_if                    out_ch();

    three_point_angle_degrees_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_triple pending_triples[$];
    t_angle  expected_angles[$];
    longint  rotation_q60[STAGES];
    int      beats_sent;
    int      beats_checked;
    int      degen_seen;
    int      total_triples;
    int      mismatches;
    logic    stimulus_done;

    // Clock.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Arctangent of 1/n in radians Q60 from truncated series terms.
    function automatic longint arctan_recip(input longint unsigned n);
        longint unsigned p;
        longint          sum;
        longint unsigned k;
        p   = (64'd1 << 60) / n;
        sum = 0;
        k   = 0;
        while (p != 0) begin
            if (k[0] == 1'b0) begin
                sum += longint'(p / (2 * k + 1));
            end else begin
                sum -= longint'(p / (2 * k + 1));
            end
            p = p / n / n;
            k++;
        end
        return sum;
    endfunction

    // Scale the first n entries together until each magnitude is below 2^30.
    function automatic void scale_below_limit(inout longint w[4], input int n);
        longint unsigned peak;
        longint unsigned m;
        int              sh;
        peak = 0;
        for (int i = 0; i < n; i++) begin
            m = (w[i] < 0) ? 64'd0 - longint'(w[i]) : w[i];
            if (m > peak) begin
                peak = m;
            end
        end
        sh = 0;
        while (sh < 63 && (peak >> sh) >= (64'd1 << 30)) begin
            sh++;
        end
        for (int i = 0; i < n; i++) begin
            w[i] = w[i] >>> sh;
        end
    endfunction

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bit_v;
        res   = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) begin
            bit_v >>= 2;
        end
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n  -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Predicted angle at the origin point between the two end points.
    function automatic t_angle vertex_angle(input t_triple t);
        t_angle          r;
        longint          a[4];
        longint          b[4];
        longint          v[4];
        longint          x, y, z, tmp, xs, ys;
        longint unsigned sq, z30, deg, ang;
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'(t.pt[3 + k]) - longint'(t.pt[k]);
            b[k] = longint'(t.pt[6 + k]) - longint'(t.pt[k]);
        end
        a[3] = 0;
        b[3] = 0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
            r.angle = '0;
            r.degen = 1'b1;
            return r;
        end
        scale_below_limit(a, 3);
        scale_below_limit(b, 3);
        v[0] = a[1] * b[2] - a[2] * b[1];
        v[1] = a[2] * b[0] - a[0] * b[2];
        v[2] = a[0] * b[1] - a[1] * b[0];
        v[3] = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        scale_below_limit(v, 4);
        sq = longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
        x  = v[3];
        y  = longint'(int_root(sq));
        z  = 0;
        // A negative dot product is pre-rotated by a quarter turn.
        if (x < 0) begin
            tmp = x;
            x   = y;
            y   = -tmp;
            z   = 2 * rotation_q60[0];
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += rotation_q60[i];
            end else begin
                x -= ys;
                y += xs;
                z -= rotation_q60[i];
            end
        end
        if (z < 0) begin
            z = 0;
        end
        z30 = (longint'(z) + (64'd1 << 29)) >> 30;
        deg = z30 * 64'd3845054675;
        ang = (deg + (64'd1 << (55 - FRAC))) >> (56 - FRAC);
        if (ang > (64'd180 << FRAC)) begin
            ang = 64'd180 << FRAC;
        end
        r.angle = ang[ANGLE_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic t_triple make_triple(input logic signed [31:0] ox, oy, oz,
                                            input logic signed [31:0] fx, fy, fz,
                                            input logic signed [31:0] sx, sy, sz);
        t_triple t;
        t.pt = '{ox, oy, oz, fx, fy, fz, sx, sy, sz};
        return t;
    endfunction

    function automatic logic signed [31:0] rand_coord(input int kind);
        logic signed [31:0] c;
        case (kind)
            0: c = $urandom;
            1: c = $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
            2: c = $signed(32'($urandom_range(0, 15))) - 32'sd8;
            default: c = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
        return c;
    endfunction

    // Random triple: mostly general geometry, plus near-collinear and
    // zero-length cases.
    function automatic t_triple random_triple();
        t_triple t;
        int      kind;
        int      shape;
        int      mul;
        kind  = $urandom_range(0, 9);
        kind  = (kind < 5) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            t.pt[i] = rand_coord(kind);
        end
        if (shape == 0) begin
            // Second point near the line through the origin and the first, on either side.
            mul = $urandom_range(0, 1) ? 1 : -1;
            for (int k = 0; k < 3; k++) begin
                t.pt[k]     = rand_coord(1);
                t.pt[3 + k] = t.pt[k] + rand_coord(1);
                t.pt[6 + k] = t.pt[k] + mul * (t.pt[3 + k] - t.pt[k]) + rand_coord(2) / 4;
            end
        end else if (shape == 1) begin
            for (int k = 0; k < 3; k++) begin
                t.pt[$urandom_range(0, 1) ? 3 + k : 6 + k] = t.pt[k];
            end
        end
        return t;
    endfunction

    // Input driver: holds a beat until it is taken, with idle bursts between.
    int in_gap;
    always @(posedge i_clk) begin
        t_triple cur;
        logic    quiet;
        quiet = (total_triples - beats_sent) < QUIET_TAIL;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                cur.pt = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
                           in_ch.first_x, in_ch.first_y, in_ch.first_z,
                           in_ch.second_x, in_ch.second_y, in_ch.second_z};
                expected_angles.push_back(vertex_angle(cur));
                void'(pending_triples.pop_front());
                beats_sent <= beats_sent + 1;
            end
            if (in_ch.valid && !in_ch.ready) begin
                in_ch.valid <= 1'b1;
            end else if (in_gap > 0 && !quiet) begin
                in_ch.valid <= 1'b0;
                in_gap      <= in_gap - 1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                in_ch.valid <= 1'b0;
                in_gap      <= $urandom_range(0, 11);
            end else if (pending_triples.size() > 0) begin
                cur = pending_triples[0];
                in_ch.valid    <= 1'b1;
                in_ch.origin_x <= cur.pt[0];
                in_ch.origin_y <= cur.pt[1];
                in_ch.origin_z <= cur.pt[2];
                in_ch.first_x  <= cur.pt[3];
                in_ch.first_y  <= cur.pt[4];
                in_ch.first_z  <= cur.pt[5];
                in_ch.second_x <= cur.pt[6];
                in_ch.second_y <= cur.pt[7];
                in_ch.second_z <= cur.pt[8];
                in_gap         <= 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output monitor: random stall bursts, in-order compare of each beat.
    int out_stall;
    always @(posedge i_clk) begin
        t_angle exp_v;
        logic   quiet;
        quiet = (total_triples - beats_sent) < QUIET_TAIL;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_angles.size() == 0) begin
                    $error("result beat with no expected angle: angle=%0d degenerate=%0b",
                           out_ch.angle_degrees, out_ch.degenerate);
                    mismatches++;
                end else begin
                    exp_v = expected_angles.pop_front();
                    if (out_ch.angle_degrees !== exp_v.angle) begin
                        $error("angle_degrees: expected %0d, actual %0d",
                               exp_v.angle, out_ch.angle_degrees);
                        mismatches++;
                    end
                    if (out_ch.degenerate !== exp_v.degen) begin
                        $error("degenerate: expected %0b, actual %0b",
                               exp_v.degen, out_ch.degenerate);
                        mismatches++;
                    end
                    if (exp_v.degen) begin
                        degen_seen++;
                    end
                end
                beats_checked++;
            end
            if (out_stall > 0 && !quiet) begin
                out_ch.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                out_ch.ready <= 1'b0;
                out_stall    <= $urandom_range(0, 11);
            end else begin
                out_ch.ready <= 1'b1;
                out_stall    <= 0;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (!stimulus_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout with %0d angles outstanding", expected_angles.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx            = 32'sh7fffffff;
        mn            = 32'sh80000000;
        beats_sent    = 0;
        beats_checked = 0;
        degen_seen    = 0;
        mismatches    = 0;
        stimulus_done = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.origin_z = '0;
        in_ch.first_x  = '0;
        in_ch.first_y  = '0;
        in_ch.first_z  = '0;
        in_ch.second_x = '0;
        in_ch.second_y = '0;
        in_ch.second_z = '0;
        out_ch.ready   = 1'b0;
        for (int i = 0; i < STAGES; i++) begin
            rotation_q60[i] = (i == 0) ? 4 * arctan_recip(5) - arctan_recip(239)
                                       : arctan_recip(64'd1 << i);
        end

        // Directed: zero-length vectors, the principal angles and extremes.
        pending_triples.push_back(make_triple(5, 6, 7, 5, 6, 7, 9, 9, 9));
        pending_triples.push_back(make_triple(5, 6, 7, 9, 9, 9, 5, 6, 7));
        pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_triples.push_back(make_triple(mn, mn, mn, mn, mn, mn, mx, mx, mx));
        pending_triples.push_back(make_triple(0, 0, 0, 65536, 0, 0, 131072, 0, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 65536, 0, 0, -65536, 0, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 1, 0, 1, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 1, 0, 0, -1, 0, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 1, 1, 0, -1, 0, 0));
        pending_triples.push_back(make_triple(mn, mn, mn, mx, mx, mx, mx, mx, mx));
        pending_triples.push_back(make_triple(mx, mx, mx, mn, mn, mn, mn, mn, mn));
        pending_triples.push_back(make_triple(mx, mx, mx, mn, mn, mn, mx, mx, mn));
        pending_triples.push_back(make_triple(mn, 0, 0, mx, 0, 0, mn, mx, 0));
        pending_triples.push_back(make_triple(mx, mn, mx, mn, mx, mn, mx, mx, mn));
        pending_triples.push_back(make_triple(0, 0, 0, mx, 0, 0, mn, 1, 0));
        pending_triples.push_back(make_triple(0, 0, 0, mx, mx, mx, 1, 1, 1));
        pending_triples.push_back(make_triple(-1, -1, -1, -1, -1, 0, 0, -1, -1));
        pending_triples.push_back(make_triple(0, 0, 0, 3, 4, 0, -4, 3, 1));
        pending_triples.push_back(make_triple(0, 0, 0, mx, 1, 0, mx, 0, 0));
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pending_triples.push_back(random_triple());
        end
        total_triples = pending_triples.size();

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_sent < total_triples || expected_angles.size() > 0) begin
            @(posedge i_clk);
        end
        stimulus_done = 1'b1;
        repeat (100) @(posedge i_clk);

        $display("Checked %0d angles from %0d point triples, %0d of them degenerate.",
                 beats_checked, total_triples, degen_seen);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
